@@ src/int64_accumulator_alu_macros.svh @@
// ----------------------------------------------------------------------------
// int64_accumulator_alu assertion macros
// Short forms for the concurrent checks in the accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef INT64_ACCUMULATOR_ALU_MACROS_SVH
`define INT64_ACCUMULATOR_ALU_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define CHK_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/i64acc_pkg.sv @@
// ----------------------------------------------------------------------------
// i64acc_pkg
// Widths, opcodes and shared types of the 64-bit accumulator ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i64acc_pkg;

   localparam int DATA_WIDTH  = 64;
   localparam int CNT_WIDTH   = $clog2(DATA_WIDTH + 1);
   localparam int OUT_WIDTH   = 64;
   localparam int RET_WIDTH   = 32;
   localparam int CMD_WIDTH   = 5;
   localparam int SHAMT_WIDTH = 6;

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_LOAD   = 5'd0,
      CMD_ADD    = 5'd1,
      CMD_SUB    = 5'd2,
      CMD_MUL    = 5'd3,
      CMD_DIV    = 5'd4,
      CMD_MOD    = 5'd5,
      CMD_SHL    = 5'd6,
      CMD_SAR    = 5'd7,
      CMD_EQ     = 5'd8,
      CMD_NE     = 5'd9,
      CMD_LE     = 5'd10,
      CMD_LT     = 5'd11,
      CMD_GE     = 5'd12,
      CMD_GT     = 5'd13,
      CMD_AND    = 5'd14,
      CMD_OR     = 5'd15,
      CMD_XOR    = 5'd16,
      CMD_LAND   = 5'd17,
      CMD_LOR    = 5'd18,
      CMD_LXOR   = 5'd19,
      CMD_NEG    = 5'd20,
      CMD_LNOT   = 5'd21,
      CMD_INVERT = 5'd22
   } cmd_type;

   // request into the shared multiply/divide unit
   typedef struct packed {
      logic     start;
      logic     is_div;
      word_type a;
      word_type b;
   } md_req_type;

   // status and results of the shared unit; results hold until the next start
   typedef struct packed {
      logic     done;
      word_type product;
      word_type quotient;
      word_type remainder;
   } md_rsp_type;

   function automatic logic [OUT_WIDTH-1:0] sext_out(word_type x);
      return OUT_WIDTH'($signed(x));
   endfunction

endpackage

@@ src/i64acc_muldiv.sv @@
// ----------------------------------------------------------------------------
// i64acc_muldiv
// Bit-serial multiply and signed divide around one shared adder/subtractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i64acc_muldiv
   import i64acc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  md_req_type md_req,
   output md_rsp_type md_rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEGA,
      ST_NEGB,
      ST_RUN,
      ST_FIXQ,
      ST_FIXR
   } state_type;

   state_type              state_ff;
   logic                   is_div_ff;
   logic                   sa_ff;
   logic                   sb_ff;
   word_type               x_ff;   // product / partial remainder
   word_type               y_ff;   // multiplicand / divisor
   word_type               z_ff;   // multiplier / dividend then quotient
   logic [CNT_WIDTH-1:0]   cnt_ff;
   logic                   done_ff;

   logic [DATA_WIDTH:0]    add_x;
   logic [DATA_WIDTH:0]    add_y;
   logic                   add_sub;
   logic [DATA_WIDTH:0]    add_sum;
   word_type               rem_sh;

   assign rem_sh = {x_ff[DATA_WIDTH-2:0], z_ff[DATA_WIDTH-1]};

   // the one adder; negation is 0 - value
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b1;
      unique case (state_ff)
         ST_NEGA: begin
            add_y = {1'b0, z_ff};
         end
         ST_NEGB: begin
            add_y = {1'b0, y_ff};
         end
         ST_RUN: begin
            if (is_div_ff) begin
               add_x = {1'b0, rem_sh};
               add_y = {1'b0, y_ff};
            end else begin
               add_sub = 1'b0;
               add_x   = {1'b0, x_ff};
               add_y   = z_ff[0] ? {1'b0, y_ff} : '0;
            end
         end
         ST_FIXQ: begin
            add_y = {1'b0, z_ff};
         end
         ST_FIXR: begin
            add_y = {1'b0, x_ff};
         end
         default: begin
            add_y = '0;
         end
      endcase
      add_sum = add_x + (add_sub ? ~add_y : add_y) + (DATA_WIDTH + 1)'(add_sub);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (md_req.start) begin
                  is_div_ff <= md_req.is_div;
                  sa_ff     <= md_req.is_div & md_req.a[DATA_WIDTH-1];
                  sb_ff     <= md_req.is_div & md_req.b[DATA_WIDTH-1];
                  x_ff      <= '0;
                  y_ff      <= md_req.b;
                  z_ff      <= md_req.a;
                  cnt_ff    <= '0;
                  state_ff  <= ST_NEGA;
               end
            end
            ST_NEGA: begin
               if (sa_ff) begin
                  z_ff <= add_sum[DATA_WIDTH-1:0];
               end
               state_ff <= ST_NEGB;
            end
            ST_NEGB: begin
               if (sb_ff) begin
                  y_ff <= add_sum[DATA_WIDTH-1:0];
               end
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               if (is_div_ff) begin
                  // restoring step: keep the difference when no borrow
                  x_ff <= add_sum[DATA_WIDTH] ? rem_sh : add_sum[DATA_WIDTH-1:0];
                  z_ff <= {z_ff[DATA_WIDTH-2:0], ~add_sum[DATA_WIDTH]};
               end else begin
                  x_ff <= add_sum[DATA_WIDTH-1:0];
                  y_ff <= {y_ff[DATA_WIDTH-2:0], 1'b0};
                  z_ff <= {1'b0, z_ff[DATA_WIDTH-1:1]};
               end
               cnt_ff <= cnt_ff + CNT_WIDTH'(1);
               if (cnt_ff == CNT_WIDTH'(DATA_WIDTH - 1)) begin
                  state_ff <= ST_FIXQ;
               end
            end
            ST_FIXQ: begin
               if (sa_ff ^ sb_ff) begin
                  z_ff <= add_sum[DATA_WIDTH-1:0];
               end
               state_ff <= ST_FIXR;
            end
            ST_FIXR: begin
               // remainder follows the dividend's sign
               if (sa_ff) begin
                  x_ff <= add_sum[DATA_WIDTH-1:0];
               end
               done_ff  <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign md_rsp.done      = done_ff;
   assign md_rsp.product   = x_ff;
   assign md_rsp.quotient  = z_ff;
   assign md_rsp.remainder = x_ff;

endmodule

@@ src/int64_accumulator_alu.sv @@
// ----------------------------------------------------------------------------
// int64_accumulator_alu
// Signed accumulator ALU: one opcode and operand in, one result word out.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: req_tuser carries the opcode, req_tdata the operand. A word
//   is taken when req_tvalid and req_tready are both high; req_tready is high
//   only while no operation is in flight.
//   rsp channel: one word per request. rsp_tdata holds the returned value in
//   the low 32 bits and the new accumulator above it; rsp_tuser is the
//   returned-value flag.
//   Flow: single-step ops go from ST_IDLE to ST_DONE and then to the output
//   register; mul, div and mod first wait in ST_WAIT while the shared
//   multiply/divide unit runs one bit per cycle through its one adder. A new
//   request is taken only after the previous result has been loaded.
//   Reset (synchronous) clears the accumulator and drops both handshakes.
//   A stalled rsp keeps its word in the output register; a finished result
//   waits in ST_DONE until the output is free; then the next request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "int64_accumulator_alu_macros.svh"

module int64_accumulator_alu
   import i64acc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] operand
   input  logic [4:0]  req_tuser,   // [4:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] ret_value, [95:32] acc_out
   output logic        rsp_tuser    // [0] ret_valid
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type               state_ff;
   cmd_type                 cmd_ff;
   word_type                opnd_ff;
   word_type                acc_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_ret_valid_ff;
   logic [RET_WIDTH-1:0]    rsp_ret_value_ff;
   logic [OUT_WIDTH-1:0]    rsp_acc_ff;

   md_req_type              md_req;
   md_rsp_type              md_rsp;

   logic                    accept;
   logic                    is_md;
   logic                    out_load;
   cmd_type                 req_cmd;

   word_type                acc_in;
   logic                    ret_valid_in;
   logic [RET_WIDTH-1:0]    ret_value_in;
   logic [OUT_WIDTH-1:0]    and_wide;
   logic [OUT_WIDTH-1:0]    xor_wide;
   logic [SHAMT_WIDTH-1:0]  shamt;

   assign req_cmd    = cmd_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign is_md      = (req_cmd == CMD_MUL) || (req_cmd == CMD_DIV) || (req_cmd == CMD_MOD);
   assign out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   assign md_req.start  = accept && is_md;
   assign md_req.is_div = (req_cmd != CMD_MUL);
   assign md_req.a      = acc_ff;
   assign md_req.b      = req_tdata[DATA_WIDTH-1:0];

   i64acc_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   assign shamt    = opnd_ff[SHAMT_WIDTH-1:0];
   assign and_wide = sext_out(acc_ff & opnd_ff);
   assign xor_wide = sext_out(acc_ff ^ opnd_ff);

   always_comb begin
      acc_in       = acc_ff;
      ret_valid_in = 1'b0;
      ret_value_in = '0;
      unique case (cmd_ff)
         CMD_LOAD:   acc_in = opnd_ff;
         CMD_ADD:    acc_in = acc_ff + opnd_ff;
         CMD_SUB:    acc_in = acc_ff - opnd_ff;
         CMD_MUL:    acc_in = md_rsp.product;
         CMD_DIV:    acc_in = (opnd_ff == '0) ? '0 : md_rsp.quotient;
         CMD_MOD:    acc_in = (opnd_ff == '0) ? '0 : md_rsp.remainder;
         CMD_SHL:    acc_in = acc_ff << shamt;
         CMD_SAR:    acc_in = word_type'($signed(acc_ff) >>> shamt);
         CMD_EQ: begin
            ret_valid_in = 1'b1;
            ret_value_in = RET_WIDTH'(acc_ff == opnd_ff);
         end
         CMD_NE: begin
            ret_valid_in = 1'b1;
            ret_value_in = RET_WIDTH'(acc_ff != opnd_ff);
         end
         CMD_LE: begin
            ret_valid_in = 1'b1;
            ret_value_in = RET_WIDTH'($signed(acc_ff) <= $signed(opnd_ff));
         end
         CMD_LT: begin
            ret_valid_in = 1'b1;
            ret_value_in = RET_WIDTH'($signed(acc_ff) < $signed(opnd_ff));
         end
         CMD_GE: begin
            ret_valid_in = 1'b1;
            ret_value_in = RET_WIDTH'($signed(acc_ff) >= $signed(opnd_ff));
         end
         CMD_GT: begin
            ret_valid_in = 1'b1;
            ret_value_in = RET_WIDTH'($signed(acc_ff) > $signed(opnd_ff));
         end
         CMD_AND: begin
            acc_in       = acc_ff & opnd_ff;
            ret_valid_in = 1'b1;
            ret_value_in = and_wide[RET_WIDTH-1:0];
         end
         CMD_OR:     acc_in = acc_ff | opnd_ff;
         CMD_XOR:    acc_in = acc_ff ^ opnd_ff;
         CMD_LAND: begin
            ret_valid_in = 1'b1;
            ret_value_in = RET_WIDTH'((acc_ff != '0) && (opnd_ff != '0));
         end
         CMD_LOR: begin
            ret_valid_in = 1'b1;
            ret_value_in = RET_WIDTH'((acc_ff != '0) || (opnd_ff != '0));
         end
         CMD_LXOR: begin
            ret_valid_in = 1'b1;
            ret_value_in = xor_wide[RET_WIDTH-1:0];
         end
         CMD_NEG:    acc_in = '0 - acc_ff;
         CMD_LNOT:   acc_in = word_type'(acc_ff == '0);
         CMD_INVERT: acc_in = ~acc_ff;
         default:    acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a word stays until taken; a new one loads as the slot frees
         rsp_valid_ff <= out_load || (rsp_valid_ff && !rsp_tready);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff   <= req_cmd;
                  opnd_ff  <= req_tdata[DATA_WIDTH-1:0];
                  state_ff <= is_md ? ST_WAIT : ST_DONE;
               end
            end
            ST_WAIT: begin
               if (md_rsp.done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_load) begin
                  acc_ff           <= acc_in;
                  rsp_ret_valid_ff <= ret_valid_in;
                  rsp_ret_value_ff <= ret_value_in;
                  rsp_acc_ff       <= sext_out(acc_in);
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_acc_ff, rsp_ret_value_ff};
   assign rsp_tuser  = rsp_ret_valid_ff;

   `CHK_NEXT(a_one_in_flight, accept, !req_tready, "request taken while busy")
   `CHK_IMPL(a_done_in_wait, md_rsp.done, state_ff == ST_WAIT, "unit done outside wait")
   `CHK_NEXT(a_acc_hold, !out_load, $stable(acc_ff), "accumulator moved without a result")
   `CHK_IMPL(a_ret_zero, rsp_tvalid && !rsp_tuser, rsp_tdata[31:0] == '0, "stray returned value")

endmodule
